@@ rtl/sct_pkg.sv @@
// shared types, constants and helper functions for the source character tokenizer
// no dependencies; imported by sct_scan, sct_outq, the top, the token checker and the testbench
package sct_pkg;

    localparam int LINE_WIDTH = 16;
    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);

    // token kinds
    localparam logic [3:0] KIND_ID     = 4'd0;
    localparam logic [3:0] KIND_INT    = 4'd1;
    localparam logic [3:0] KIND_STRING = 4'd2;
    localparam logic [3:0] KIND_EQUAL  = 4'd3;
    localparam logic [3:0] KIND_SEMI   = 4'd4;
    localparam logic [3:0] KIND_LPAREN = 4'd5;
    localparam logic [3:0] KIND_RPAREN = 4'd6;
    localparam logic [3:0] KIND_LBRACE = 4'd7;
    localparam logic [3:0] KIND_RBRACE = 4'd8;
    localparam logic [3:0] KIND_EOF    = 4'd9;
    localparam logic [3:0] KIND_ERR    = 4'd10;

    // error codes
    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_UNEXP   = 2'd1;
    localparam logic [1:0] ERR_NOQUOTE = 2'd2;

    // characters of interest
    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_NL      = 8'h0A;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_EQUAL   = 8'h3D;
    localparam logic [7:0] CH_UNDER   = 8'h5F;
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;

    typedef enum logic [7:0] {
        MODE_IDLE   = 8'b0000_0001,
        MODE_NUM    = 8'b0000_0010,
        MODE_ID     = 8'b0000_0100,
        MODE_STR0   = 8'b0000_1000,
        MODE_STR    = 8'b0001_0000,
        MODE_CMT    = 8'b0010_0000,
        MODE_DONE   = 8'b0100_0000,
        MODE_SILENT = 8'b1000_0000
    } scan_mode_t;

    typedef struct packed {
        logic [3:0]  token_kind;
        logic [7:0]  value_byte;
        logic        has_byte;
        logic        token_first;
        logic        token_last;
        logic [15:0] line_number;
        logic [1:0]  error_code;
        logic        last_of_run;
    } sct_res_t;

    // up to two results written into the output queue per transaction
    typedef struct packed {
        logic [1:0] count;
        sct_res_t   r0;
        sct_res_t   r1;
    } sct_wr_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c inside {[8'h30:8'h39]});
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return (c inside {[8'h41:8'h5A], [8'h61:8'h7A]});
    endfunction

    function automatic sct_res_t make_res(input logic [3:0] kind, input logic [7:0] byte_val,
                                          input logic hasb, input logic first,
                                          input logic last, input logic [1:0] err,
                                          input logic [15:0] line);
        sct_res_t r;
        r.token_kind  = kind;
        r.value_byte  = hasb ? byte_val : 8'h00;
        r.has_byte    = hasb;
        r.token_first = first;
        r.token_last  = last;
        r.line_number = line;
        r.error_code  = err;
        r.last_of_run = 1'b0;
        return r;
    endfunction

endpackage

@@ rtl/sct_scan.sv @@
// scan mode and line counter, plus the per-character result decode
// depends on sct_pkg
module sct_scan import sct_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       accept,
    input  logic [7:0] char_byte,
    input  logic       end_of_input,
    output sct_wr_t    wr
);

    scan_mode_t            mode_reg, mode_next;
    logic [LINE_WIDTH-1:0] line_reg, line_next;
    logic                  line_inc;

    logic [31:0] line_wide;
    logic [15:0] line_sat;

    logic       is_end;
    logic       idle_emit, idle_inc;
    scan_mode_t idle_mode;
    sct_res_t   idle_res;

    logic [1:0] n;
    sct_res_t   r0, r1;

    assign line_wide = 32'(line_reg);
    assign line_sat  = (line_wide > 32'h0000_FFFF) ? 16'hFFFF : line_wide[15:0];
    assign is_end    = end_of_input || (char_byte == CH_NUL);

    // what a character does when seen from idle
    always_comb begin
        idle_emit = 1'b0;
        idle_inc  = 1'b0;
        idle_mode = MODE_IDLE;
        idle_res  = make_res(KIND_ERR, 8'h00, 1'b0, 1'b1, 1'b1, ERR_UNEXP, line_sat);
        if (char_byte == CH_SPACE) begin
            idle_emit = 1'b0;
        end else if (char_byte == CH_NL) begin
            idle_inc = 1'b1;
        end else if (char_byte == CH_HASH) begin
            idle_mode = MODE_CMT;
        end else if (char_byte == CH_QUOTE) begin
            idle_mode = MODE_STR0;
        end else if (char_byte == CH_EQUAL) begin
            idle_emit = 1'b1;
            idle_res  = make_res(KIND_EQUAL, char_byte, 1'b1, 1'b1, 1'b1, ERR_NONE, line_sat);
        end else if (char_byte == CH_SEMI) begin
            idle_emit = 1'b1;
            idle_res  = make_res(KIND_SEMI, char_byte, 1'b1, 1'b1, 1'b1, ERR_NONE, line_sat);
        end else if (char_byte == CH_LPAREN) begin
            idle_emit = 1'b1;
            idle_res  = make_res(KIND_LPAREN, char_byte, 1'b1, 1'b1, 1'b1, ERR_NONE, line_sat);
        end else if (char_byte == CH_RPAREN) begin
            idle_emit = 1'b1;
            idle_res  = make_res(KIND_RPAREN, char_byte, 1'b1, 1'b1, 1'b1, ERR_NONE, line_sat);
        end else if (char_byte == CH_LBRACE) begin
            idle_emit = 1'b1;
            idle_res  = make_res(KIND_LBRACE, char_byte, 1'b1, 1'b1, 1'b1, ERR_NONE, line_sat);
        end else if (char_byte == CH_RBRACE) begin
            idle_emit = 1'b1;
            idle_res  = make_res(KIND_RBRACE, char_byte, 1'b1, 1'b1, 1'b1, ERR_NONE, line_sat);
        end else if (is_digit(char_byte)) begin
            idle_emit = 1'b1;
            idle_mode = MODE_NUM;
            idle_res  = make_res(KIND_INT, char_byte, 1'b1, 1'b1, 1'b0, ERR_NONE, line_sat);
        end else if (is_letter(char_byte)) begin
            idle_emit = 1'b1;
            idle_mode = MODE_ID;
            idle_res  = make_res(KIND_ID, char_byte, 1'b1, 1'b1, 1'b0, ERR_NONE, line_sat);
        end else begin
            idle_emit = 1'b1;
            idle_mode = MODE_SILENT;
        end
    end

    always_comb begin
        n         = 2'd0;
        r0        = idle_res;
        r1        = idle_res;
        mode_next = mode_reg;
        line_inc  = 1'b0;
        if (is_end) begin
            case (mode_reg)
                MODE_NUM, MODE_ID: begin
                    n         = 2'd2;
                    r0        = make_res((mode_reg == MODE_NUM) ? KIND_INT : KIND_ID, 8'h00,
                                         1'b0, 1'b0, 1'b1, ERR_NONE, line_sat);
                    r1        = make_res(KIND_EOF, 8'h00, 1'b0, 1'b1, 1'b1, ERR_NONE, line_sat);
                    mode_next = MODE_DONE;
                end
                MODE_STR0, MODE_STR: begin
                    n         = 2'd1;
                    r0        = make_res(KIND_ERR, 8'h00, 1'b0, 1'b1, 1'b1, ERR_NOQUOTE,
                                         line_sat);
                    mode_next = MODE_SILENT;
                end
                MODE_SILENT: begin
                    n = 2'd0;
                end
                default: begin
                    n         = 2'd1;
                    r0        = make_res(KIND_EOF, 8'h00, 1'b0, 1'b1, 1'b1, ERR_NONE, line_sat);
                    mode_next = MODE_DONE;
                end
            endcase
        end else begin
            case (mode_reg)
                MODE_IDLE: begin
                    n         = {1'b0, idle_emit};
                    r0        = idle_res;
                    mode_next = idle_mode;
                    line_inc  = idle_inc;
                end
                MODE_NUM, MODE_ID: begin
                    if (is_digit(char_byte) || ((mode_reg == MODE_ID) &&
                        (is_letter(char_byte) || char_byte == CH_UNDER))) begin
                        n  = 2'd1;
                        r0 = make_res((mode_reg == MODE_NUM) ? KIND_INT : KIND_ID, char_byte,
                                      1'b1, 1'b0, 1'b0, ERR_NONE, line_sat);
                    end else begin
                        // close the token, then rescan the terminator from idle
                        n         = idle_emit ? 2'd2 : 2'd1;
                        r0        = make_res((mode_reg == MODE_NUM) ? KIND_INT : KIND_ID,
                                             8'h00, 1'b0, 1'b0, 1'b1, ERR_NONE, line_sat);
                        r1        = idle_res;
                        mode_next = idle_mode;
                        line_inc  = idle_inc;
                    end
                end
                MODE_STR0, MODE_STR: begin
                    n = 2'd1;
                    if (char_byte == CH_QUOTE) begin
                        r0        = make_res(KIND_STRING, 8'h00, 1'b0, mode_reg == MODE_STR0,
                                             1'b1, ERR_NONE, line_sat);
                        mode_next = MODE_IDLE;
                    end else begin
                        r0        = make_res(KIND_STRING, char_byte, 1'b1,
                                             mode_reg == MODE_STR0, 1'b0, ERR_NONE, line_sat);
                        mode_next = MODE_STR;
                        line_inc  = (char_byte == CH_NL);
                    end
                end
                MODE_CMT: begin
                    if (char_byte == CH_NL) begin
                        line_inc  = 1'b1;
                        mode_next = MODE_IDLE;
                    end
                end
                default: begin
                    n = 2'd0;
                end
            endcase
        end
        if (n == 2'd2) begin
            r1.last_of_run = 1'b1;
        end else begin
            r0.last_of_run = 1'b1;
        end
    end

    always_comb begin
        line_next = line_reg;
        if (line_inc && (line_reg != {LINE_WIDTH{1'b1}})) begin
            line_next = line_reg + LINE_WIDTH'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_IDLE;
            line_reg <= LINE_WIDTH'(1);
        end else if (accept) begin
            mode_reg <= mode_next;
            line_reg <= line_next;
        end
    end

    assign wr.count = accept ? n : 2'd0;
    assign wr.r0    = r0;
    assign wr.r1    = r1;

endmodule

@@ rtl/sct_outq.sv @@
// small result queue: takes up to two results per cycle, hands out one per cycle while out_ready is high
// depends on sct_pkg
module sct_outq import sct_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  sct_wr_t  wr,
    output logic     room,
    output logic     out_valid,
    input  logic     out_ready,
    output sct_res_t out_res
);

    sct_res_t           entry_reg [OUTQ_DEPTH];
    logic [OUTQ_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [OUTQ_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [OUTQ_AW:0]   count_reg, count_next;
    logic               pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = (count_reg != '0);
    assign out_res   = entry_reg[rd_ptr_reg];
    // two free slots are needed since one transaction can produce two results
    assign room      = (count_reg <= (OUTQ_AW+1)'(OUTQ_DEPTH - 2));

    always_comb begin
        wr_ptr_next = wr_ptr_reg + OUTQ_AW'(wr.count);
        rd_ptr_next = rd_ptr_reg + OUTQ_AW'(pop);
        count_next  = count_reg + (OUTQ_AW+1)'(wr.count) - (OUTQ_AW+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr.count != 2'd0) begin
            entry_reg[wr_ptr_reg] <= wr.r0;
        end
        if (wr.count == 2'd2) begin
            entry_reg[wr_ptr_reg + OUTQ_AW'(1)] <= wr.r1;
        end
    end

endmodule

@@ rtl/source_char_tokenizer_top.sv @@
// output: each result is registered in the result queue and shows on m_ once the results ahead of it have left
// throughput: one character per cycle while each gives at most one result and m_ready
// stays high; a character that closes a token and starts another gives two results,
// which leave the four-entry result queue one per cycle while m_ready is high
// reset: aresetn synchronous active low; scan mode to idle, line count to one, queue empty
// depends on sct_pkg, sct_scan, sct_outq
module source_char_tokenizer_top import sct_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_char_byte,
    input  logic        s_end_of_input,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_token_kind,
    output logic [7:0]  m_value_byte,
    output logic        m_has_byte,
    output logic        m_token_first,
    output logic        m_token_last,
    output logic [15:0] m_line_number,
    output logic [1:0]  m_error_code,
    output logic        m_last_of_run
);

    logic     accept;
    logic     room;
    sct_wr_t  wr;
    sct_res_t res;

    assign s_ready = room;
    assign accept  = s_valid && room;

    sct_scan u_scan (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (accept),
        .char_byte    (s_char_byte),
        .end_of_input (s_end_of_input),
        .wr           (wr)
    );

    sct_outq u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr        (wr),
        .room      (room),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_res   (res)
    );

    assign m_token_kind  = res.token_kind;
    assign m_value_byte  = res.value_byte;
    assign m_has_byte    = res.has_byte;
    assign m_token_first = res.token_first;
    assign m_token_last  = res.token_last;
    assign m_line_number = res.line_number;
    assign m_error_code  = res.error_code;
    assign m_last_of_run = res.last_of_run;

endmodule

@@ tb/sct_token_checker.sv @@
// token checker for the source character tokenizer: predicts the result pieces of each
// accepted character transaction and compares them with the m_ channel, field by field
// depends on sct_pkg for the result struct, token kinds, error codes and characters
module sct_token_checker import sct_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_char_byte,
    input  logic        s_end_of_input,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [3:0]  m_token_kind,
    input  logic [7:0]  m_value_byte,
    input  logic        m_has_byte,
    input  logic        m_token_first,
    input  logic        m_token_last,
    input  logic [15:0] m_line_number,
    input  logic [1:0]  m_error_code,
    input  logic        m_last_of_run,
    output int          mismatches,
    output int          pieces_due,
    output int          pieces_seen,
    output int          chars_taken
);

    scan_mode_t  mode;
    logic [15:0] line_cnt;
    sct_res_t    expected_pieces[$];
    sct_res_t    step_buf[2];
    int          step_n;

    initial begin
        mismatches  = 0;
        pieces_due  = 0;
        pieces_seen = 0;
        chars_taken = 0;
        mode        = MODE_IDLE;
        line_cnt    = 16'd1;
        step_n      = 0;
    end

    function automatic logic is_dec(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    endfunction

    task automatic flag_mismatch(input string msg);
        mismatches++;
        $display("mismatch at result %0d: %s", pieces_seen, msg);
    endtask

    task automatic bump_line();
        if (line_cnt != 16'hFFFF)
            line_cnt++;
    endtask

    task automatic add_piece(input logic [3:0] kind, input logic [7:0] b, input logic hb,
                             input logic first, input logic last, input logic [1:0] err);
        sct_res_t p;
        p.token_kind  = kind;
        p.value_byte  = hb ? b : 8'h00;
        p.has_byte    = hb;
        p.token_first = first;
        p.token_last  = last;
        p.line_number = line_cnt;
        p.error_code  = err;
        p.last_of_run = 1'b0;
        step_buf[step_n] = p;
        step_n++;
    endtask

    task automatic scan_from_idle(input logic [7:0] c);
        case (c)
            CH_SPACE: ;
            CH_NL:     bump_line();
            CH_HASH:   mode = MODE_CMT;
            CH_QUOTE:  mode = MODE_STR0;
            CH_EQUAL:  add_piece(KIND_EQUAL, c, 1'b1, 1'b1, 1'b1, ERR_NONE);
            CH_SEMI:   add_piece(KIND_SEMI, c, 1'b1, 1'b1, 1'b1, ERR_NONE);
            CH_LPAREN: add_piece(KIND_LPAREN, c, 1'b1, 1'b1, 1'b1, ERR_NONE);
            CH_RPAREN: add_piece(KIND_RPAREN, c, 1'b1, 1'b1, 1'b1, ERR_NONE);
            CH_LBRACE: add_piece(KIND_LBRACE, c, 1'b1, 1'b1, 1'b1, ERR_NONE);
            CH_RBRACE: add_piece(KIND_RBRACE, c, 1'b1, 1'b1, 1'b1, ERR_NONE);
            default: begin
                if (is_dec(c)) begin
                    add_piece(KIND_INT, c, 1'b1, 1'b1, 1'b0, ERR_NONE);
                    mode = MODE_NUM;
                end else if (is_alpha(c)) begin
                    add_piece(KIND_ID, c, 1'b1, 1'b1, 1'b0, ERR_NONE);
                    mode = MODE_ID;
                end else begin
                    add_piece(KIND_ERR, 8'h00, 1'b0, 1'b1, 1'b1, ERR_UNEXP);
                    mode = MODE_SILENT;
                end
            end
        endcase
    endtask

    task automatic scan_char(input logic [7:0] c, input logic eoi);
        logic first_piece;
        step_n = 0;
        // a zero byte counts as the end mark
        if (eoi || c == CH_NUL) begin
            case (mode)
                MODE_NUM, MODE_ID: begin
                    add_piece((mode == MODE_NUM) ? KIND_INT : KIND_ID, 8'h00, 1'b0, 1'b0, 1'b1,
                              ERR_NONE);
                    add_piece(KIND_EOF, 8'h00, 1'b0, 1'b1, 1'b1, ERR_NONE);
                    mode = MODE_DONE;
                end
                MODE_STR0, MODE_STR: begin
                    add_piece(KIND_ERR, 8'h00, 1'b0, 1'b1, 1'b1, ERR_NOQUOTE);
                    mode = MODE_SILENT;
                end
                MODE_SILENT: ;
                default: begin
                    add_piece(KIND_EOF, 8'h00, 1'b0, 1'b1, 1'b1, ERR_NONE);
                    mode = MODE_DONE;
                end
            endcase
        end else begin
            case (mode)
                MODE_IDLE: scan_from_idle(c);
                MODE_NUM: begin
                    if (is_dec(c)) begin
                        add_piece(KIND_INT, c, 1'b1, 1'b0, 1'b0, ERR_NONE);
                    end else begin
                        add_piece(KIND_INT, 8'h00, 1'b0, 1'b0, 1'b1, ERR_NONE);
                        mode = MODE_IDLE;
                        scan_from_idle(c);
                    end
                end
                MODE_ID: begin
                    if (is_dec(c) || is_alpha(c) || c == CH_UNDER) begin
                        add_piece(KIND_ID, c, 1'b1, 1'b0, 1'b0, ERR_NONE);
                    end else begin
                        add_piece(KIND_ID, 8'h00, 1'b0, 1'b0, 1'b1, ERR_NONE);
                        mode = MODE_IDLE;
                        scan_from_idle(c);
                    end
                end
                MODE_STR0, MODE_STR: begin
                    first_piece = (mode == MODE_STR0);
                    if (c == CH_QUOTE) begin
                        add_piece(KIND_STRING, 8'h00, 1'b0, first_piece, 1'b1, ERR_NONE);
                        mode = MODE_IDLE;
                    end else begin
                        // the piece keeps the line it started on, the count moves after it
                        add_piece(KIND_STRING, c, 1'b1, first_piece, 1'b0, ERR_NONE);
                        mode = MODE_STR;
                        if (c == CH_NL)
                            bump_line();
                    end
                end
                MODE_CMT: begin
                    if (c == CH_NL) begin
                        bump_line();
                        mode = MODE_IDLE;
                    end
                end
                default: ;
            endcase
        end
        if (step_n > 0)
            step_buf[step_n - 1].last_of_run = 1'b1;
        for (int i = 0; i < step_n; i++)
            expected_pieces.push_back(step_buf[i]);
    endtask

    task automatic cmp_field(input string name, input logic [15:0] got, input logic [15:0] want);
        if (got !== want)
            flag_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    task automatic check_piece();
        sct_res_t want;
        if (expected_pieces.size() == 0) begin
            flag_mismatch($sformatf("result of kind %0d with nothing expected", m_token_kind));
        end else begin
            want = expected_pieces.pop_front();
            cmp_field("token_kind", 16'(m_token_kind), 16'(want.token_kind));
            cmp_field("value_byte", 16'(m_value_byte), 16'(want.value_byte));
            cmp_field("has_byte", 16'(m_has_byte), 16'(want.has_byte));
            cmp_field("token_first", 16'(m_token_first), 16'(want.token_first));
            cmp_field("token_last", 16'(m_token_last), 16'(want.token_last));
            cmp_field("line_number", m_line_number, want.line_number);
            cmp_field("error_code", 16'(m_error_code), 16'(want.error_code));
            cmp_field("last_of_run", 16'(m_last_of_run), 16'(want.last_of_run));
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            mode     = MODE_IDLE;
            line_cnt = 16'd1;
            expected_pieces.delete();
        end else begin
            if (s_valid && s_ready) begin
                scan_char(s_char_byte, s_end_of_input);
                chars_taken++;
            end
            if (m_valid && m_ready) begin
                check_piece();
                pieces_seen++;
            end
        end
        pieces_due = expected_pieces.size();
    end

endmodule

@@ tb/tb_source_char_tokenizer_top.sv @@
// testbench top for the source character tokenizer: drives character transactions and
// handshake pressure, and gives the verdict from the failure count of the checker
// depends on sct_pkg, sct_token_checker and source_char_tokenizer_top
module tb_source_char_tokenizer_top;
    import sct_pkg::*;

    localparam int QUIET_LIMIT = 2000;

    logic        aclk           = 1'b0;
    logic        aresetn        = 1'b0;
    logic        s_valid        = 1'b0;
    logic        s_ready;
    logic [7:0]  s_char_byte    = 8'h00;
    logic        s_end_of_input = 1'b0;
    logic        m_valid;
    logic        m_ready        = 1'b0;
    logic [3:0]  m_token_kind;
    logic [7:0]  m_value_byte;
    logic        m_has_byte;
    logic        m_token_first;
    logic        m_token_last;
    logic [15:0] m_line_number;
    logic [1:0]  m_error_code;
    logic        m_last_of_run;

    int    mismatches;
    int    pieces_due;
    int    pieces_seen;
    int    chars_taken;
    int    chars_sent     = 0;
    int    send_idle_pct  = 0;
    int    recv_stall_pct = 0;
    int    quiet_cycles   = 0;
    int    idle_tab[4]    = '{0, 45, 0, 35};
    int    stall_tab[4]   = '{0, 0, 45, 35};
    string ending_name    = "";

    source_char_tokenizer_top DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_char_byte    (s_char_byte),
        .s_end_of_input (s_end_of_input),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_token_kind   (m_token_kind),
        .m_value_byte   (m_value_byte),
        .m_has_byte     (m_has_byte),
        .m_token_first  (m_token_first),
        .m_token_last   (m_token_last),
        .m_line_number  (m_line_number),
        .m_error_code   (m_error_code),
        .m_last_of_run  (m_last_of_run)
    );

    sct_token_checker token_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_char_byte    (s_char_byte),
        .s_end_of_input (s_end_of_input),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_token_kind   (m_token_kind),
        .m_value_byte   (m_value_byte),
        .m_has_byte     (m_has_byte),
        .m_token_first  (m_token_first),
        .m_token_last   (m_token_last),
        .m_line_number  (m_line_number),
        .m_error_code   (m_error_code),
        .m_last_of_run  (m_last_of_run),
        .mismatches     (mismatches),
        .pieces_due     (pieces_due),
        .pieces_seen    (pieces_seen),
        .chars_taken    (chars_taken)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // cycles in which no transaction moves on either channel
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: %0d cycles without a transaction", quiet_cycles);
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic logic [7:0] pick_letter();
        int r;
        r = $urandom_range(51);
        return (r < 26) ? 8'(8'h61 + r) : 8'(8'h41 + r - 26);
    endfunction

    function automatic logic [7:0] pick_digit();
        return 8'(8'h30 + $urandom_range(9));
    endfunction

    function automatic logic [7:0] pick_punct();
        case ($urandom_range(5))
            0:       return CH_EQUAL;
            1:       return CH_SEMI;
            2:       return CH_LPAREN;
            3:       return CH_RPAREN;
            4:       return CH_LBRACE;
            default: return CH_RBRACE;
        endcase
    endfunction

    // any non-zero byte except the one that would close the string or comment
    function automatic logic [7:0] pick_body_byte(input logic [7:0] banned);
        logic [7:0] b;
        do b = 8'($urandom_range(255, 1)); while (b == banned);
        return b;
    endfunction

    // called at a rising edge; returns just after the edge that takes the transaction
    task automatic send_char(input logic [7:0] c, input logic eoi);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid        <= 1'b1;
        s_char_byte    <= c;
        s_end_of_input <= eoi;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        chars_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], 1'b0);
    endtask

    // hold the sender off until every predicted piece has come out; ends at a falling edge
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(negedge aclk); while (pieces_due != 0);
    endtask

    // one well-formed token with random content, or a short run of loose characters
    task automatic send_lexeme();
        int sel;
        sel = $urandom_range(99);
        if (sel < 22) begin
            send_char(pick_letter(), 1'b0);
            repeat ($urandom_range(5)) begin
                case ($urandom_range(2))
                    0:       send_char(pick_letter(), 1'b0);
                    1:       send_char(pick_digit(), 1'b0);
                    default: send_char(CH_UNDER, 1'b0);
                endcase
            end
        end else if (sel < 40) begin
            repeat ($urandom_range(5, 1)) send_char(pick_digit(), 1'b0);
        end else if (sel < 55) begin
            send_char(CH_QUOTE, 1'b0);
            repeat ($urandom_range(6)) send_char(pick_body_byte(CH_QUOTE), 1'b0);
            send_char(CH_QUOTE, 1'b0);
        end else if (sel < 63) begin
            send_char(CH_HASH, 1'b0);
            repeat ($urandom_range(6)) send_char(pick_body_byte(CH_NL), 1'b0);
            send_char(CH_NL, 1'b0);
        end else if (sel < 80) begin
            send_char(pick_punct(), 1'b0);
        end else begin
            // a random run of letters, digits, punctuation, spaces and newlines
            repeat ($urandom_range(4, 1)) begin
                case ($urandom_range(4))
                    0:       send_char(pick_letter(), 1'b0);
                    1:       send_char(pick_digit(), 1'b0);
                    2:       send_char(pick_punct(), 1'b0);
                    3:       send_char(CH_SPACE, 1'b0);
                    default: send_char(CH_NL, 1'b0);
                endcase
            end
        end
        if ($urandom_range(99) < 50)
            send_char(($urandom_range(3) == 0) ? CH_NL : CH_SPACE, 1'b0);
    endtask

    initial begin
        int ph;
        int target;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: empty string, string with extreme bytes and a newline, every kind but eof and error
        send_text("\"\"");
        send_char(CH_QUOTE, 1'b0);
        send_char(8'h01, 1'b0);
        send_char(8'hFF, 1'b0);
        send_char(CH_NL, 1'b0);
        send_char(CH_QUOTE, 1'b0);
        send_text("A_Z9=");
        send_text("09(");
        send_text("z\n");
        send_text("){};");
        send_char(CH_HASH, 1'b0);
        send_char(8'h80, 1'b0);
        send_char(CH_NL, 1'b0);
        send_char(CH_SPACE, 1'b0);

        for (ph = 0; ph < 4; ph++) begin
            wait_drained();
            send_idle_pct  = idle_tab[ph];
            recv_stall_pct = stall_tab[ph];
            @(posedge aclk);
            target = chars_sent + 131;
            while (chars_sent < target)
                send_lexeme();
        end

        // only one way out of the scanner per run, chosen by the seed
        wait_drained();
        @(posedge aclk);
        send_char(CH_SPACE, 1'b0);
        case ($urandom_range(5))
            0: begin
                ending_name = "identifier open at end mark";
                send_char(pick_letter(), 1'b0);
                send_char(8'($urandom), 1'b1);
            end
            1: begin
                ending_name = "integer open at zero byte";
                send_char(pick_digit(), 1'b0);
                send_char(CH_NUL, 1'b0);
            end
            2: begin
                ending_name = "comment open at end mark";
                send_char(CH_HASH, 1'b0);
                send_char(pick_body_byte(CH_NL), 1'b0);
                send_char(8'($urandom), 1'b1);
            end
            3: begin
                ending_name = "unexpected character";
                case ($urandom_range(2))
                    0:       send_char(CH_UNDER, 1'b0);
                    1:       send_char(8'($urandom_range(255, 128)), 1'b0);
                    default: send_char("!", 1'b0);
                endcase
            end
            4: begin
                ending_name = "string open at end mark";
                send_char(CH_QUOTE, 1'b0);
                repeat ($urandom_range(2)) send_char(pick_body_byte(CH_QUOTE), 1'b0);
                send_char(8'($urandom), 1'b1);
            end
            default: begin
                ending_name = "end mark from idle";
                send_char(8'($urandom), 1'b1);
            end
        endcase
        // after eof only end marks answer; after an error nothing does
        repeat (4) send_char(8'($urandom), 1'($urandom_range(1)));

        wait_drained();
        repeat (8) @(posedge aclk);
        $display("covered %0d character transactions and %0d result pieces over four handshake",
                 chars_taken, pieces_seen);
        $display("phases, ending with %s", ending_name);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/sct_pkg.sv
rtl/sct_scan.sv
rtl/sct_outq.sv
rtl/source_char_tokenizer_top.sv
tb/sct_token_checker.sv
tb/tb_source_char_tokenizer_top.sv
